// ----- hdl/s2rgb_pkg.sv -----
// Shared types, constants and helper functions of the scalar to RGB colormap unit.
package s2rgb_pkg;

  // Level format and derived datapath widths.
  localparam int FRAC_BITS  = 16;
  localparam int LEVEL_W    = 18;
  localparam int COLOR_W    = 8;
  localparam int XW         = FRAC_BITS + 1;   // clamped level, holds 1.0
  localparam int UW         = FRAC_BITS + 5;   // twenty times the level
  localparam int SEG_W      = 5;               // breakpoint multiple of 0.05
  localparam int K_W        = 18;              // slope constant 25599 * mul
  localparam int PW         = K_W + UW;        // slope product
  localparam int Q_W        = 20;              // product scaled down by 1.0
  localparam int Q_DROP     = 5;               // divide by 4000 = by 32, then by 125
  localparam int V_W        = Q_W - Q_DROP;
  localparam int RECIP_W    = 18;
  localparam int RECIP_SH   = 24;
  localparam int T_W        = V_W + RECIP_W;

  // ceil(2^24 / 125); exact floor division for every value below 2^15.
  localparam logic [RECIP_W-1:0] RECIP_125 = 18'd134218;

  // Full scale breakpoint: twenty steps of 0.05.
  localparam logic [SEG_W-1:0] SEG_FULL = 5'd20;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam int PAL_W      = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MARKER  = 1'b1;

  typedef enum logic [PAL_W-1:0] {
    PAL_GRAY     = 3'd0,
    PAL_INV_GRAY = 3'd1,
    PAL_WARM     = 3'd2,
    PAL_PHASE    = 3'd3,
    PAL_ABC      = 3'd4,
    PAL_RGB      = 3'd5
  } pal_t;

  typedef enum logic [1:0] {MUL2, MUL5, MUL8, MUL10} mul_t;

  typedef enum logic [1:0] {OP_CONST, OP_ADD, OP_SUB} op_t;

  // How one color channel is formed from the ramp of the current segment.
  typedef struct packed {
    mul_t                 mul;
    op_t                  op;
    logic [COLOR_W-1:0]   base;
  } chan_t;

  function automatic logic [K_W-1:0] ramp_k(input mul_t m);
    logic [K_W-1:0] k;
    unique case (m)
      MUL2:    k = 18'd51198;
      MUL5:    k = 18'd127995;
      MUL8:    k = 18'd204792;
      MUL10:   k = 18'd255990;
      default: k = 18'd51198;
    endcase
    return k;
  endfunction

  function automatic logic [UW-1:0] seg_base(input logic [SEG_W-1:0] m);
    return {m, {FRAC_BITS{1'b0}}};
  endfunction

  function automatic chan_t ramp_ch(input mul_t m, input op_t o,
                                    input logic [COLOR_W-1:0] b);
    chan_t c;
    c.mul  = m;
    c.op   = o;
    c.base = b;
    return c;
  endfunction

  function automatic chan_t const_ch(input logic [COLOR_W-1:0] b);
    chan_t c;
    c.mul  = MUL2;
    c.op   = OP_CONST;
    c.base = b;
    return c;
  endfunction

endpackage

// ----- hdl/s2rgb_if.sv -----
// Valid/ready channel interfaces for levels in and colors out.
interface s2rgb_level_if;
  import s2rgb_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [LEVEL_W-1:0]  level;

  modport source (output valid, level, input ready);
  modport sink   (input valid, level, output ready);
  modport mon    (input valid, ready, level);
endinterface

interface s2rgb_color_if;
  import s2rgb_pkg::*;

  logic                valid;
  logic                ready;
  logic [COLOR_W-1:0]  red;
  logic [COLOR_W-1:0]  green;
  logic [COLOR_W-1:0]  blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
  modport mon    (input valid, ready, red, green, blue);
endinterface

// ----- hdl/scalar_to_rgb_colormap_unit.sv -----
// Top level of the scalar to RGB colormap unit: a five stage pipelined false color map.
//
// A signed Q2.16 level word enters on in_if and a red/green/blue word leaves on
// out_if; both are valid/ready channels and a word moves when valid and ready
// are high at a rising edge. Palette and out-of-range behavior come from two registers
// the user must write via cfg_we/cfg_index/cfg_data only while idle; not enforced.
//
// One word is taken every cycle unless a stalled out_if backs the pipe up.
// The pipeline stages are clamp and scale, segment decode, slope multiply,
// reciprocal multiply for the divide by 4000, and the final add or subtract
// into the output register. Each stage holds at most one multiplier per color
// channel.
//
// Every stage carries its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up and a stalled receiver backs the
// pipe up one stage at a time. Nothing is dropped or repeated; in_if.ready
// falls only when all five stages hold words and out_if is stalled.
//
// Synchronous reset clears the valid bits and the configuration registers
// (gray palette, clamping); in_if.ready is held low while reset is asserted.
module scalar_to_rgb_colormap_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  s2rgb_level_if.sink                       in_if,
  s2rgb_color_if.source                     out_if,
  input  logic                              cfg_we,
  input  logic [s2rgb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [s2rgb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import s2rgb_pkg::*;

  localparam logic signed [39:0] ONE_EXT = 40'sh1 << FRAC_BITS;

  // Configuration registers.
  logic [PAL_W-1:0] palette_r;
  logic             marker_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_r <= '0;
      marker_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PALETTE: palette_r <= cfg_data[PAL_W-1:0];
        REG_MARKER:  marker_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline valid bits and the backward ready chain.
  logic a_v_r, b_v_r, c_v_r, d_v_r, e_v_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

  assign rdy_e = !e_v_r || out_if.ready;
  assign rdy_d = !d_v_r || rdy_e;
  assign rdy_c = !c_v_r || rdy_d;
  assign rdy_b = !b_v_r || rdy_c;
  assign rdy_a = !a_v_r || rdy_b;

  assign in_if.ready = rst_n && rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
    end else begin
      if (rdy_a) a_v_r <= in_if.valid;
      if (rdy_b) b_v_r <= a_v_r;
      if (rdy_c) c_v_r <= b_v_r;
      if (rdy_d) d_v_r <= c_v_r;
      if (rdy_e) e_v_r <= d_v_r;
    end
  end

  // Stage A: range check, clamp into [0, 1.0] and scale by twenty, so that
  // the breakpoints at multiples of 0.05 become multiples of 1.0.
  logic signed [39:0] lv_ext;
  logic               below, above;
  logic [XW-1:0]      x_nxt;
  logic [UW-1:0]      a_u_nxt;
  pal_t               a_sel_nxt;
  logic               a_mark_nxt;

  logic [UW-1:0]      a_u_r;
  pal_t               a_sel_r;
  logic               a_mark_r;

  always_comb begin
    lv_ext = 40'(in_if.level);
    below  = in_if.level[LEVEL_W-1];
    above  = lv_ext > ONE_EXT;
    if (below) begin
      x_nxt = '0;
    end else if (above) begin
      x_nxt = ONE_EXT[XW-1:0];
    end else begin
      x_nxt = lv_ext[XW-1:0];
    end
    a_u_nxt    = (UW'(x_nxt) << 4) + (UW'(x_nxt) << 2);
    a_mark_nxt = (below || above) && marker_r;
    // Codes past the last palette fall back to gray.
    if (palette_r > PAL_RGB) begin
      a_sel_nxt = PAL_GRAY;
    end else begin
      a_sel_nxt = pal_t'(palette_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_u_r    <= a_u_nxt;
      a_sel_r  <= a_sel_nxt;
      a_mark_r <= a_mark_nxt;
    end
  end

  // Stage B: pick the segment, the offset into it and the recipe of each
  // channel (constant, or base plus or minus the segment's ramp).
  logic [SEG_W-1:0] seg_m;
  logic             inv;
  chan_t [2:0]      b_ch_nxt;
  logic [UW-1:0]    b_d_nxt;

  chan_t [2:0]      b_ch_r;
  logic [UW-1:0]    b_d_r;

  always_comb begin
    seg_m    = '0;
    inv      = 1'b0;
    b_ch_nxt = {3{ramp_ch(MUL2, OP_ADD, 8'd0)}};
    unique case (a_sel_r)
      PAL_INV_GRAY: begin
        inv = 1'b1;
      end
      PAL_WARM: begin
        if (a_u_r < seg_base(5'd4)) begin
          b_ch_nxt = {ramp_ch(MUL10, OP_ADD, 8'd0), const_ch(8'd0), const_ch(8'd0)};
        end else if (a_u_r < seg_base(5'd8)) begin
          seg_m    = 5'd4;
          b_ch_nxt = {const_ch(8'd255), const_ch(8'd0), ramp_ch(MUL10, OP_ADD, 8'd0)};
        end else if (a_u_r < seg_base(5'd12)) begin
          seg_m    = 5'd8;
          b_ch_nxt = {ramp_ch(MUL10, OP_SUB, 8'd255), const_ch(8'd0), const_ch(8'd255)};
        end else if (a_u_r < seg_base(5'd16)) begin
          seg_m    = 5'd12;
          b_ch_nxt = {const_ch(8'd0), ramp_ch(MUL10, OP_ADD, 8'd0), const_ch(8'd255)};
        end else begin
          seg_m    = 5'd16;
          b_ch_nxt = {ramp_ch(MUL10, OP_ADD, 8'd0), const_ch(8'd255), const_ch(8'd255)};
        end
      end
      PAL_PHASE: begin
        if (a_u_r < seg_base(5'd5)) begin
          b_ch_nxt = {const_ch(8'd0), const_ch(8'd0), ramp_ch(MUL8, OP_ADD, 8'd0)};
        end else if (a_u_r < seg_base(5'd10)) begin
          seg_m    = 5'd5;
          b_ch_nxt = {ramp_ch(MUL8, OP_ADD, 8'd0), ramp_ch(MUL8, OP_ADD, 8'd0),
                      const_ch(8'd255)};
        end else if (a_u_r < seg_base(5'd15)) begin
          seg_m    = 5'd10;
          b_ch_nxt = {const_ch(8'd255), ramp_ch(MUL8, OP_SUB, 8'd255),
                      ramp_ch(MUL8, OP_SUB, 8'd255)};
        end else begin
          seg_m    = 5'd15;
          b_ch_nxt = {ramp_ch(MUL8, OP_SUB, 8'd255), const_ch(8'd0), const_ch(8'd0)};
        end
      end
      PAL_ABC: begin
        if (a_u_r < seg_base(5'd4)) begin
          b_ch_nxt = {ramp_ch(MUL5, OP_SUB, 8'd255), const_ch(8'd255),
                      ramp_ch(MUL5, OP_SUB, 8'd255)};
        end else if (a_u_r < seg_base(5'd8)) begin
          seg_m    = 5'd4;
          b_ch_nxt = {const_ch(8'd128), const_ch(8'd255), ramp_ch(MUL5, OP_ADD, 8'd128)};
        end else if (a_u_r < seg_base(5'd12)) begin
          seg_m    = 5'd8;
          b_ch_nxt = {ramp_ch(MUL5, OP_SUB, 8'd128), ramp_ch(MUL5, OP_SUB, 8'd255),
                      const_ch(8'd255)};
        end else if (a_u_r < seg_base(5'd14)) begin
          seg_m    = 5'd12;
          b_ch_nxt = {const_ch(8'd0), ramp_ch(MUL10, OP_SUB, 8'd128), const_ch(8'd255)};
        end else if (a_u_r < seg_base(5'd16)) begin
          seg_m    = 5'd14;
          b_ch_nxt = {ramp_ch(MUL5, OP_ADD, 8'd0), const_ch(8'd0),
                      ramp_ch(MUL10, OP_SUB, 8'd255)};
        end else if (a_u_r < seg_base(5'd18)) begin
          seg_m    = 5'd16;
          b_ch_nxt = {ramp_ch(MUL5, OP_ADD, 8'd64), const_ch(8'd0),
                      ramp_ch(MUL10, OP_SUB, 8'd128)};
        end else begin
          seg_m    = 5'd18;
          b_ch_nxt = {ramp_ch(MUL10, OP_SUB, 8'd128), const_ch(8'd0), const_ch(8'd0)};
        end
      end
      PAL_RGB: begin
        if (a_u_r < seg_base(5'd5)) begin
          b_ch_nxt = {ramp_ch(MUL8, OP_ADD, 8'd0), const_ch(8'd0), const_ch(8'd0)};
        end else if (a_u_r < seg_base(5'd10)) begin
          seg_m    = 5'd5;
          b_ch_nxt = {ramp_ch(MUL8, OP_SUB, 8'd255), ramp_ch(MUL8, OP_ADD, 8'd0),
                      const_ch(8'd0)};
        end else if (a_u_r < seg_base(5'd15)) begin
          seg_m    = 5'd10;
          b_ch_nxt = {const_ch(8'd0), ramp_ch(MUL8, OP_SUB, 8'd255),
                      ramp_ch(MUL8, OP_ADD, 8'd0)};
        end else begin
          seg_m    = 5'd15;
          b_ch_nxt = {ramp_ch(MUL8, OP_ADD, 8'd0), ramp_ch(MUL8, OP_ADD, 8'd0),
                      const_ch(8'd255)};
        end
      end
      default: ;
    endcase

    // Marker colors replace the whole recipe for an out-of-range level.
    if (a_mark_r) begin
      if (a_sel_r == PAL_ABC) begin
        b_ch_nxt = {const_ch(8'd128), const_ch(8'd128), const_ch(8'd128)};
      end else if (a_sel_r == PAL_RGB) begin
        b_ch_nxt = {const_ch(8'd128), const_ch(8'd255), const_ch(8'd255)};
      end else begin
        b_ch_nxt = {const_ch(8'd0), const_ch(8'd255), const_ch(8'd0)};
      end
    end

    // Inverted gray runs its ramp down from full scale.
    if (inv) begin
      b_d_nxt = seg_base(SEG_FULL) - a_u_r;
    end else begin
      b_d_nxt = a_u_r - seg_base(seg_m);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      b_ch_r <= b_ch_nxt;
      b_d_r  <= b_d_nxt;
    end
  end

  // Stage C: slope multiply and divide by 1.0 (a shift). The segment limits
  // keep the scaled product below 4000 * 256, so it fits in Q_W bits.
  logic [PW-1:0]     prod [3];
  logic [Q_W-1:0]    c_q_nxt [3];
  logic [Q_W-1:0]    c_q_r [3];
  chan_t [2:0]       c_ch_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i]    = PW'(ramp_k(b_ch_r[i].mul)) * PW'(b_d_r);
      c_q_nxt[i] = prod[i][FRAC_BITS+Q_W-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      c_q_r  <= c_q_nxt;
      c_ch_r <= b_ch_r;
    end
  end

  // Stage D: the remaining divide by 4000, done as a shift by 5 and a
  // multiply by the reciprocal of 125.
  logic [T_W-1:0]     quot [3];
  logic [COLOR_W-1:0] d_ramp_nxt [3];
  logic [COLOR_W-1:0] d_ramp_r [3];
  chan_t [2:0]        d_ch_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quot[i]       = T_W'(c_q_r[i][Q_W-1:Q_DROP]) * T_W'(RECIP_125);
      d_ramp_nxt[i] = quot[i][RECIP_SH+COLOR_W-1:RECIP_SH];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d) begin
      d_ramp_r <= d_ramp_nxt;
      d_ch_r   <= c_ch_r;
    end
  end

  // Stage E: apply the recipe into the output register. The segment decode
  // lists blue first in each concatenation, so index 0 is red, 1 green and
  // 2 blue.
  logic [COLOR_W-1:0] e_col_nxt [3];
  logic [COLOR_W-1:0] e_col_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (d_ch_r[i].op)
        OP_ADD:  e_col_nxt[i] = d_ch_r[i].base + d_ramp_r[i];
        OP_SUB:  e_col_nxt[i] = d_ch_r[i].base - d_ramp_r[i];
        default: e_col_nxt[i] = d_ch_r[i].base;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_e) begin
      e_col_r <= e_col_nxt;
    end
  end

  assign out_if.valid = e_v_r;
  assign out_if.red   = e_col_r[0];
  assign out_if.green = e_col_r[1];
  assign out_if.blue  = e_col_r[2];

endmodule

// ----- hdl/s2rgb_checker.sv -----
// Port-level assertion checker for the colormap unit and its bind statement.
module s2rgb_checker
  import s2rgb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_ready,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [COLOR_W-1:0]  out_red,
  input  logic [COLOR_W-1:0]  out_green,
  input  logic [COLOR_W-1:0]  out_blue
);

  // Reset empties the pipe: no word can appear on the next edge.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // The pipe is five stages deep, so the first word after reset must pass through all of them.
  a_fill_latency: assert property (@(posedge clk)
    !rst_n ##1 rst_n |-> !out_valid ##1 !out_valid ##1 !out_valid
                         ##1 !out_valid ##1 !out_valid)
    else $error("output word earlier than the pipeline depth allows");

  // The input side only backs up when the output holds a stalled word.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled output word");

  // A stalled output word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red)
      && $stable(out_green) && $stable(out_blue))
    else $error("stalled output word changed or dropped");

endmodule

bind scalar_to_rgb_colormap_unit s2rgb_checker u_s2rgb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_red   (out_if.red),
  .out_green (out_if.green),
  .out_blue  (out_if.blue)
);
